[rtl/acc_exec_pkg.sv]
// ----------------------------------------------------------------------------
// acc_exec_pkg: shared types and constants
// Decoded instruction record passed from the decoder to the execute stage.
// ----------------------------------------------------------------------------
package acc_exec_pkg;

  localparam logic [4:0] K_NOP  = 5'd0;
  localparam logic [4:0] K_ADC  = 5'd1;
  localparam logic [4:0] K_LD   = 5'd2;
  localparam logic [4:0] K_ST   = 5'd3;
  localparam logic [4:0] K_ORA  = 5'd4;
  localparam logic [4:0] K_EOR  = 5'd5;
  localparam logic [4:0] K_CMP  = 5'd6;
  localparam logic [4:0] K_SETF = 5'd7;
  localparam logic [4:0] K_CLRF = 5'd8;
  localparam logic [4:0] K_INC  = 5'd9;
  localparam logic [4:0] K_DEC  = 5'd10;
  localparam logic [4:0] K_TR   = 5'd11;
  localparam logic [4:0] K_PHA  = 5'd12;
  localparam logic [4:0] K_PLA  = 5'd13;
  localparam logic [4:0] K_JMP  = 5'd14;
  localparam logic [4:0] K_BRS  = 5'd15;
  localparam logic [4:0] K_BRC  = 5'd16;
  localparam logic [4:0] K_BAD  = 5'd17;

  localparam logic [3:0] M_IMP  = 4'd0;
  localparam logic [3:0] M_IMM  = 4'd1;
  localparam logic [3:0] M_ZP   = 4'd2;
  localparam logic [3:0] M_ZPX  = 4'd3;
  localparam logic [3:0] M_ZPY  = 4'd4;
  localparam logic [3:0] M_ABS  = 4'd5;
  localparam logic [3:0] M_ABX  = 4'd6;
  localparam logic [3:0] M_ABY  = 4'd7;
  localparam logic [3:0] M_REL  = 4'd8;
  localparam logic [3:0] M_JABS = 4'd9;
  localparam logic [3:0] M_JIND = 4'd10;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;

  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_N = 8'h80;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;
  localparam logic [7:0] STACK_PAGE  = 8'h01;
  localparam logic [7:0] SELF_BRANCH = 8'hFE;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [4:0] kind;
    logic [3:0] mode;
    logic [7:0] arg;
  } dec_t;

  typedef struct packed {
    dec_t       dec;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] rd;
    logic [7:0] rdh;
  } qitem_t;

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t d;
    d = '{kind: K_BAD, mode: M_IMP, arg: 8'd0};
    unique case (opc)
      8'hEA: d = '{K_NOP, M_IMP, 8'd0};
      8'h69: d = '{K_ADC, M_IMM, 8'd0};
      8'h65: d = '{K_ADC, M_ZP, 8'd0};
      8'h75: d = '{K_ADC, M_ZPX, 8'd0};
      8'h6D: d = '{K_ADC, M_ABS, 8'd0};
      8'h7D: d = '{K_ADC, M_ABX, 8'd0};
      8'h79: d = '{K_ADC, M_ABY, 8'd0};
      8'hA9: d = '{K_LD, M_IMM, 8'd0};
      8'hA5: d = '{K_LD, M_ZP, 8'd0};
      8'hB5: d = '{K_LD, M_ZPX, 8'd0};
      8'hAD: d = '{K_LD, M_ABS, 8'd0};
      8'hBD: d = '{K_LD, M_ABX, 8'd0};
      8'hB9: d = '{K_LD, M_ABY, 8'd0};
      8'hA2: d = '{K_LD, M_IMM, 8'd1};
      8'hA6: d = '{K_LD, M_ZP, 8'd1};
      8'hB6: d = '{K_LD, M_ZPY, 8'd1};
      8'hAE: d = '{K_LD, M_ABS, 8'd1};
      8'hBE: d = '{K_LD, M_ABY, 8'd1};
      8'hA0: d = '{K_LD, M_IMM, 8'd2};
      8'hA4: d = '{K_LD, M_ZP, 8'd2};
      8'hB4: d = '{K_LD, M_ZPX, 8'd2};
      8'hAC: d = '{K_LD, M_ABS, 8'd2};
      8'hBC: d = '{K_LD, M_ABX, 8'd2};
      8'h18: d = '{K_CLRF, M_IMP, FL_C};
      8'h38: d = '{K_SETF, M_IMP, FL_C};
      8'h58: d = '{K_CLRF, M_IMP, FL_I};
      8'h78: d = '{K_SETF, M_IMP, FL_I};
      8'hB8: d = '{K_CLRF, M_IMP, FL_V};
      8'hD8: d = '{K_CLRF, M_IMP, FL_D};
      8'hF8: d = '{K_SETF, M_IMP, FL_D};
      8'h85: d = '{K_ST, M_ZP, 8'd0};
      8'h95: d = '{K_ST, M_ZPX, 8'd0};
      8'h8D: d = '{K_ST, M_ABS, 8'd0};
      8'h9D: d = '{K_ST, M_ABX, 8'd0};
      8'h99: d = '{K_ST, M_ABY, 8'd0};
      8'h86: d = '{K_ST, M_ZP, 8'd1};
      8'h96: d = '{K_ST, M_ZPY, 8'd1};
      8'h8E: d = '{K_ST, M_ABS, 8'd1};
      8'h84: d = '{K_ST, M_ZP, 8'd2};
      8'h94: d = '{K_ST, M_ZPX, 8'd2};
      8'h8C: d = '{K_ST, M_ABS, 8'd2};
      8'h05: d = '{K_ORA, M_ZP, 8'd0};
      8'h0D: d = '{K_ORA, M_ABS, 8'd0};
      8'h15: d = '{K_ORA, M_ZPX, 8'd0};
      8'h19: d = '{K_ORA, M_ABY, 8'd0};
      8'h1D: d = '{K_ORA, M_ABX, 8'd0};
      8'h4C: d = '{K_JMP, M_JABS, 8'd0};
      8'h6C: d = '{K_JMP, M_JIND, 8'd0};
      8'hD0: d = '{K_BRC, M_REL, FL_Z};
      8'hF0: d = '{K_BRS, M_REL, FL_Z};
      8'h10: d = '{K_BRC, M_REL, FL_N};
      8'h30: d = '{K_BRS, M_REL, FL_N};
      8'h90: d = '{K_BRC, M_REL, FL_C};
      8'hB0: d = '{K_BRS, M_REL, FL_C};
      8'h50: d = '{K_BRC, M_REL, FL_V};
      8'h70: d = '{K_BRS, M_REL, FL_V};
      8'hE8: d = '{K_INC, M_IMP, 8'd1};
      8'hC8: d = '{K_INC, M_IMP, 8'd2};
      8'hCA: d = '{K_DEC, M_IMP, 8'd1};
      8'h88: d = '{K_DEC, M_IMP, 8'd2};
      8'hC9: d = '{K_CMP, M_IMM, 8'd0};
      8'hC5: d = '{K_CMP, M_ZP, 8'd0};
      8'hD5: d = '{K_CMP, M_ZPX, 8'd0};
      8'hCD: d = '{K_CMP, M_ABS, 8'd0};
      8'hDD: d = '{K_CMP, M_ABX, 8'd0};
      8'hD9: d = '{K_CMP, M_ABY, 8'd0};
      8'hE0: d = '{K_CMP, M_IMM, 8'd1};
      8'hE4: d = '{K_CMP, M_ZP, 8'd1};
      8'hEC: d = '{K_CMP, M_ABS, 8'd1};
      8'hC0: d = '{K_CMP, M_IMM, 8'd2};
      8'hC4: d = '{K_CMP, M_ZP, 8'd2};
      8'hCC: d = '{K_CMP, M_ABS, 8'd2};
      8'h98: d = '{K_TR, M_IMP, 8'd8};
      8'hA8: d = '{K_TR, M_IMP, 8'd2};
      8'h8A: d = '{K_TR, M_IMP, 8'd4};
      8'hAA: d = '{K_TR, M_IMP, 8'd1};
      8'h9A: d = '{K_TR, M_IMP, 8'd7};
      8'hBA: d = '{K_TR, M_IMP, 8'd13};
      8'h49: d = '{K_EOR, M_IMM, 8'd0};
      8'h45: d = '{K_EOR, M_ZP, 8'd0};
      8'h55: d = '{K_EOR, M_ZPX, 8'd0};
      8'h4D: d = '{K_EOR, M_ABS, 8'd0};
      8'h5D: d = '{K_EOR, M_ABX, 8'd0};
      8'h59: d = '{K_EOR, M_ABY, 8'd0};
      8'h48: d = '{K_PHA, M_IMP, 8'd0};
      8'h68: d = '{K_PLA, M_IMP, 8'd0};
      default: d = '{K_BAD, M_IMP, 8'd0};
    endcase
    return d;
  endfunction

endpackage

[rtl/acc_exec_front.sv]
// ----------------------------------------------------------------------------
// acc_exec_front: decode and instruction queue
// Classifies each opcode and holds decoded items in a short FIFO.
// ----------------------------------------------------------------------------
module acc_exec_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_cmd,
  input  logic [7:0]           in_operand_low,
  input  logic [7:0]           in_operand_high,
  input  logic [7:0]           in_read_data,
  input  logic [7:0]           in_read_data_high,
  output logic                 q_valid,
  input  logic                 q_take,
  output acc_exec_pkg::qitem_t q_item
);

  acc_exec_pkg::qitem_t mem_r [acc_exec_pkg::QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_stall = (cnt_r == 2'(acc_exec_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{dec: acc_exec_pkg::decode(in_cmd), lo: in_operand_low,
                       hi: in_operand_high, rd: in_read_data, rdh: in_read_data_high};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(acc_exec_pkg::QDEPTH))
    else $error("queue count overflow");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

[rtl/acc_exec_back.sv]
// ----------------------------------------------------------------------------
// acc_exec_back: execute stage
// Holds architectural registers, runs one instruction per cycle into an
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module acc_exec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic                 q_valid,
  output logic                 q_take,
  input  acc_exec_pkg::qitem_t q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_next_pc,
  output logic [7:0]           out_acc,
  output logic [7:0]           out_index_x,
  output logic [7:0]           out_index_y,
  output logic [7:0]           out_stack_ptr,
  output logic [7:0]           out_status,
  output logic [15:0]          out_access_addr,
  output logic [1:0]           out_access_kind,
  output logic [7:0]           out_write_data,
  output logic                 out_trap,
  output logic                 out_unimplemented
);

  logic [15:0] pc_r;
  logic [7:0]  a_r, x_r, y_r, sp_r, p_r;
  logic        ov_r;
  logic [15:0] pc_nxt, addr;
  logic [7:0]  a_nxt, x_nxt, y_nxt, sp_nxt, p_nxt, val, wd, rsel, tv;
  logic [1:0]  kind;
  logic        trap, bad, fire;
  logic [8:0]  sum;
  logic [7:0]  diff;
  logic [15:0] abs_a, len;

  acc_exec_pkg::dec_t d;
  assign d = q_item.dec;

  assign q_take = !ov_r || !out_stall;
  assign fire   = q_valid && q_take;

  function automatic logic [7:0] pick(input logic [1:0] k, input logic [7:0] a,
                                      input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] s);
    logic [7:0] r;
    case (k)
      2'd0:    r = a;
      2'd1:    r = x;
      2'd2:    r = y;
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p & ~(acc_exec_pkg::FL_Z | acc_exec_pkg::FL_N);
    if (v == 8'd0) r = r | acc_exec_pkg::FL_Z;
    r = r | (v & acc_exec_pkg::FL_N);
    return r;
  endfunction

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r;
    addr  = 16'd0; kind = acc_exec_pkg::ACC_NONE; wd = 8'd0;
    trap  = 1'b0; bad = 1'b0; len = 16'd1;
    abs_a = {q_item.hi, q_item.lo};
    val   = (d.mode == acc_exec_pkg::M_IMM) ? q_item.lo : q_item.rd;
    rsel  = pick(d.arg[1:0], a_r, x_r, y_r, sp_r);
    tv    = pick(d.arg[3:2], a_r, x_r, y_r, sp_r);
    sum   = {1'b0, a_r} + {1'b0, val} + {8'd0, p_r[0]};
    diff  = rsel - val;
    unique case (d.mode)
      acc_exec_pkg::M_IMM, acc_exec_pkg::M_REL: len = 16'd2;
      acc_exec_pkg::M_ZP:  begin len = 16'd2; addr = {8'd0, q_item.lo}; end
      acc_exec_pkg::M_ZPX: begin len = 16'd2; addr = {8'd0, q_item.lo + x_r}; end
      acc_exec_pkg::M_ZPY: begin len = 16'd2; addr = {8'd0, q_item.lo + y_r}; end
      acc_exec_pkg::M_ABS, acc_exec_pkg::M_JABS, acc_exec_pkg::M_JIND: begin
        len = 16'd3; addr = abs_a;
      end
      acc_exec_pkg::M_ABX: begin len = 16'd3; addr = abs_a + {8'd0, x_r}; end
      acc_exec_pkg::M_ABY: begin len = 16'd3; addr = abs_a + {8'd0, y_r}; end
      default: ;
    endcase
    if (d.mode >= acc_exec_pkg::M_ZP && d.mode <= acc_exec_pkg::M_ABY)
      kind = acc_exec_pkg::ACC_READ;
    pc_nxt = pc_r + len;
    unique case (d.kind)
      acc_exec_pkg::K_ADC: begin
        a_nxt = sum[7:0];
        p_nxt = zn(p_r, sum[7:0]);
        p_nxt[0] = sum[8];
        p_nxt[6] = ~(a_r[7] ^ val[7]) & (a_r[7] ^ sum[7]);
      end
      acc_exec_pkg::K_LD: begin
        case (d.arg[1:0])
          2'd0:    a_nxt = val;
          2'd1:    x_nxt = val;
          default: y_nxt = val;
        endcase
        p_nxt = zn(p_r, val);
      end
      acc_exec_pkg::K_ST: begin kind = acc_exec_pkg::ACC_WRITE; wd = rsel; end
      acc_exec_pkg::K_ORA: begin a_nxt = a_r | val; p_nxt = zn(p_r, a_r | val); end
      acc_exec_pkg::K_EOR: begin a_nxt = a_r ^ val; p_nxt = zn(p_r, a_r ^ val); end
      acc_exec_pkg::K_CMP: begin
        p_nxt = zn(p_r, diff);
        p_nxt[0] = (rsel >= val);
      end
      acc_exec_pkg::K_SETF: p_nxt = p_r | d.arg;
      acc_exec_pkg::K_CLRF: p_nxt = p_r & ~d.arg;
      acc_exec_pkg::K_INC: begin
        if (d.arg[1]) y_nxt = y_r + 8'd1; else x_nxt = x_r + 8'd1;
        p_nxt = zn(p_r, rsel + 8'd1);
      end
      acc_exec_pkg::K_DEC: begin
        if (d.arg[1]) y_nxt = y_r - 8'd1; else x_nxt = x_r - 8'd1;
        p_nxt = zn(p_r, rsel - 8'd1);
      end
      acc_exec_pkg::K_TR: begin
        case (d.arg[1:0])
          2'd0:    a_nxt = tv;
          2'd1:    x_nxt = tv;
          2'd2:    y_nxt = tv;
          default: sp_nxt = tv;
        endcase
        if (d.arg[1:0] != 2'd3) p_nxt = zn(p_r, tv);
      end
      acc_exec_pkg::K_PHA: begin
        kind = acc_exec_pkg::ACC_WRITE;
        addr = {acc_exec_pkg::STACK_PAGE, sp_r};
        wd = a_r;
        sp_nxt = sp_r - 8'd1;
      end
      acc_exec_pkg::K_PLA: begin
        sp_nxt = sp_r + 8'd1;
        kind = acc_exec_pkg::ACC_READ;
        addr = {acc_exec_pkg::STACK_PAGE, sp_r + 8'd1};
        a_nxt = q_item.rd;
        p_nxt = zn(p_r, q_item.rd);
      end
      acc_exec_pkg::K_JMP: begin
        if (d.mode == acc_exec_pkg::M_JIND) begin
          kind = acc_exec_pkg::ACC_READ;
          pc_nxt = {q_item.rdh, q_item.rd};
        end else begin
          pc_nxt = addr;
        end
        trap = (pc_nxt == pc_r);
      end
      acc_exec_pkg::K_BRS, acc_exec_pkg::K_BRC: begin
        if (((p_r & d.arg) != 8'd0) == (d.kind == acc_exec_pkg::K_BRS)) begin
          trap = (q_item.lo == acc_exec_pkg::SELF_BRANCH);
          pc_nxt = pc_nxt + {{8{q_item.lo[7]}}, q_item.lo};
        end
      end
      acc_exec_pkg::K_NOP: ;
      default: begin bad = 1'b1; pc_nxt = pc_r + 16'd1; end
    endcase
    if (kind == acc_exec_pkg::ACC_NONE) addr = 16'd0;
    if (kind != acc_exec_pkg::ACC_WRITE) wd = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 16'd0; a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0;
      sp_r <= acc_exec_pkg::SP_RESET; p_r <= acc_exec_pkg::FLAGS_RESET;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) pc_r <= cfg_data;
      else if (fire) pc_r <= pc_nxt;
      if (fire) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt; p_r <= p_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_next_pc <= pc_nxt; out_acc <= a_nxt; out_index_x <= x_nxt;
      out_index_y <= y_nxt; out_stack_ptr <= sp_nxt; out_status <= p_nxt;
      out_access_addr <= addr; out_access_kind <= kind; out_write_data <= wd;
      out_trap <= trap; out_unimplemented <= bad;
    end
  end

  assign out_valid = ov_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r)
    else $error("result dropped while stalled");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (out_access_kind != 2'd3))
    else $error("bad access kind");
  a_pc_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_we) |=> (pc_r == out_next_pc))
    else $error("pc not consistent with result");

endmodule

[rtl/accumulator_cpu_instruction_executor.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_instruction_executor: 8-bit accumulator CPU subset
// An accepted input is held in a queue entry, then in the execute output register.
// Throughput: one instruction per cycle while out_stall is low; the execute register feeds back.
// Reset (rst_n low, synchronous): registers take reset values, PC = 0,
// queue and output empty. A cfg write loads the PC.
// ----------------------------------------------------------------------------
module accumulator_cpu_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_start_address,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_cmd,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  input  logic [7:0]  in_read_data,
  input  logic [7:0]  in_read_data_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_next_pc,
  output logic [7:0]  out_acc,
  output logic [7:0]  out_index_x,
  output logic [7:0]  out_index_y,
  output logic [7:0]  out_stack_ptr,
  output logic [7:0]  out_status,
  output logic [15:0] out_access_addr,
  output logic [1:0]  out_access_kind,
  output logic [7:0]  out_write_data,
  output logic        out_trap,
  output logic        out_unimplemented
);

  // Front decodes into the queue; back drains it one transfer per cycle while the output is not stalled.
  logic                 q_valid, q_take;
  acc_exec_pkg::qitem_t q_item;

  acc_exec_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_operand_low,
    .in_operand_high, .in_read_data, .in_read_data_high,
    .q_valid, .q_take, .q_item
  );

  acc_exec_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_start_address),
    .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_next_pc, .out_acc, .out_index_x,
    .out_index_y, .out_stack_ptr, .out_status, .out_access_addr,
    .out_access_kind, .out_write_data, .out_trap, .out_unimplemented
  );

endmodule
